### src/snr_pkg.sv
// ----------------------------------------------------------------------------
// snr_pkg: shared types and constants for the neighbor rulebook block
// Map row type, operation and register codes, default sizes.
// ----------------------------------------------------------------------------
package snr_pkg;

  // Default map size and kernel position cap
  localparam int MAP_DEPTH_DEF = 65536;
  localparam int KERNEL_POS_DEF = 27;

  // Width of the running map address; holds any corner address and its
  // negative excursions while stepping through the kernel.
  localparam int ADDR_W = 36;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 22;
  localparam int MUL_B_W = 17;
  localparam int PROD_W = MUL_A_W + MUL_B_W;

  typedef logic signed [16:0] row_t;
  localparam row_t ROW_EMPTY = '1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    CFG_GRID_DEPTH    = 3'd0,
    CFG_GRID_HEIGHT   = 3'd1,
    CFG_GRID_WIDTH    = 3'd2,
    CFG_BATCH_STRIDE  = 3'd3,
    CFG_KERNEL_DEPTH  = 3'd4,
    CFG_KERNEL_HEIGHT = 3'd5,
    CFG_KERNEL_WIDTH  = 3'd6
  } cfg_idx_t;

endpackage

### src/snr_req_if.sv
// ----------------------------------------------------------------------------
// snr_req_if: input item channel
// Carries map writes and voxel queries with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface snr_req_if
  import snr_pkg::*;
  ();
  logic        valid;
  logic        ready;
  op_t         operation;
  logic [15:0] map_address;
  row_t        map_value;
  logic [3:0]  batch_index;
  logic [9:0]  coord_z;
  logic [9:0]  coord_y;
  logic [9:0]  coord_x;

  modport source (
    output valid, operation, map_address, map_value, batch_index,
           coord_z, coord_y, coord_x,
    input  ready
  );

  modport sink (
    input  valid, operation, map_address, map_value, batch_index,
           coord_z, coord_y, coord_x,
    output ready
  );
endinterface

### src/snr_rsp_if.sv
// ----------------------------------------------------------------------------
// snr_rsp_if: result item channel
// One item per kernel position of a query, valid/ready handshake.
// ----------------------------------------------------------------------------
interface snr_rsp_if
  import snr_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [4:0] kernel_position;
  logic       found;
  row_t       neighbor_address;
  row_t       neighbor_row;
  logic       last;

  modport source (
    output valid, kernel_position, found, neighbor_address, neighbor_row, last,
    input  ready
  );

  modport sink (
    input  valid, kernel_position, found, neighbor_address, neighbor_row, last,
    output ready
  );
endinterface

### src/snr_cfg_if.sv
// ----------------------------------------------------------------------------
// snr_cfg_if: configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface snr_cfg_if
  import snr_pkg::*;
  ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

### src/submanifold_neighbor_rulebook_top.sv
// ----------------------------------------------------------------------------
// submanifold_neighbor_rulebook_top: neighbor search for sparse 3D convolution
// Dense voxel-to-row map with write and query items; emits one result item
// per kernel position of each queried voxel.
// ----------------------------------------------------------------------------
// After reset the block clears its map to empty, one entry a cycle;
// req.ready stays low during that pass while configuration writes are taken
// as usual. A write item goes into the map as it is taken. A query with a
// nonempty kernel holds req.ready low through the setup steps and the walk
// over its kernel positions (up to 27 for a 3x3x3 kernel): the setup reuses
// a single multiplier four times to form the corner address and the plane
// size, and the walk issues one map read per kernel position from the
// single read port. Reads pass the read stage and then the output register,
// which lets the next item in while the last results still wait to be taken.
// ----------------------------------------------------------------------------
module submanifold_neighbor_rulebook_top
  import snr_pkg::*;
#(
  parameter int MAP_DEPTH = MAP_DEPTH_DEF,
  parameter int KERNEL_POSITIONS = KERNEL_POS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  snr_req_if.sink  req,
  snr_rsp_if.source rsp,
  snr_cfg_if.sink  cfg
);

  localparam int AW = $clog2(MAP_DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAP_DEPTH - 1);
  localparam logic [ADDR_W-1:0] MAP_LIMIT = ADDR_W'(MAP_DEPTH);
  localparam logic [5:0] POS_CAP = 6'(KERNEL_POSITIONS);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SETUP = 4'b0100,
    ST_WALK  = 4'b1000
  } state_t;

  // Setup steps of the shared multiplier
  typedef enum logic [4:0] {
    SU_ZH   = 5'b00001,  // z0 * grid_height
    SU_YW   = 5'b00010,  // (z0*gh + y0) * grid_width
    SU_BS   = 5'b00100,  // batch * batch_stride, add x0
    SU_HW   = 5'b01000,  // grid_height * grid_width, add batch base
    SU_DONE = 5'b10000   // latch plane size and corner address
  } step_t;

  // Configuration registers
  logic [10:0] grid_depth, grid_height, grid_width;
  logic [16:0] batch_stride;
  logic [1:0]  kernel_depth, kernel_height, kernel_width;

  state_t state;
  step_t  step;
  logic [AW-1:0] clr_idx;

  // Query context
  logic [3:0]  q_batch;
  logic [4:0]  total;
  logic signed [11:0] cur_z, cur_y, cur_x, org_y, org_x;
  logic [1:0]  kx, ky;
  logic [4:0]  pos;

  // Shared multiplier and address cursors
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [ADDR_W-1:0]  acc;
  logic [21:0]        plane;
  logic [ADDR_W-1:0]  addr_cur, addr_row, addr_plane;

  // Read stage
  logic       b_valid, b_ok, b_last;
  logic [4:0] b_pos;
  row_t       b_addr;
  row_t       rd_data;

  // Output register
  logic       rsp_valid;
  logic [4:0] rsp_pos;
  logic       rsp_found, rsp_last;
  row_t       rsp_addr, rsp_row;

  // Map memory
  row_t          map_mem [MAP_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  row_t          mem_wd;

  logic req_take, wr_ok;
  logic [5:0] tot_raw;
  logic [4:0] tot_cap;
  logic z_in, y_in, x_in, in_map;
  logic b_take, issue, walk_last, hit;
  logic [ADDR_W-1:0] row_step, plane_step;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign req_take  = req.valid && req.ready;

  assign wr_ok = (32'(req.map_address) < 32'(MAP_DEPTH));

  // Kernel position count, capped
  assign tot_raw = 6'(kernel_depth) * 6'(kernel_height) * 6'(kernel_width);
  assign tot_cap = (tot_raw > POS_CAP) ? POS_CAP[4:0] : tot_raw[4:0];

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_depth    <= 11'd16;
      grid_height   <= 11'd16;
      grid_width    <= 11'd16;
      batch_stride  <= 17'd4096;
      kernel_depth  <= 2'd3;
      kernel_height <= 2'd3;
      kernel_width  <= 2'd3;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_GRID_DEPTH:    grid_depth    <= cfg.data[10:0];
        CFG_GRID_HEIGHT:   grid_height   <= cfg.data[10:0];
        CFG_GRID_WIDTH:    grid_width    <= cfg.data[10:0];
        CFG_BATCH_STRIDE:  batch_stride  <= cfg.data;
        CFG_KERNEL_DEPTH:  kernel_depth  <= cfg.data[1:0];
        CFG_KERNEL_HEIGHT: kernel_height <= cfg.data[1:0];
        CFG_KERNEL_WIDTH:  kernel_width  <= cfg.data[1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: operand select per setup step
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      SU_ZH: begin
        mul_a = MUL_A_W'(cur_z[10:0]);
        mul_b = MUL_B_W'(grid_height);
      end
      SU_YW: begin
        mul_a = prod[MUL_A_W-1:0] + MUL_A_W'(org_y[10:0]);
        mul_b = MUL_B_W'(grid_width);
      end
      SU_BS: begin
        mul_a = MUL_A_W'(q_batch);
        mul_b = batch_stride;
      end
      SU_HW: begin
        mul_a = MUL_A_W'(grid_height);
        mul_b = MUL_B_W'(grid_width);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Walk: bounds checks and read issue
  // ---------------------------------------------------------------------------
  assign z_in = !cur_z[11] && (cur_z[10:0] < grid_depth);
  assign y_in = !cur_y[11] && (cur_y[10:0] < grid_height);
  assign x_in = !cur_x[11] && (cur_x[10:0] < grid_width);
  assign in_map = !addr_cur[ADDR_W-1] && (addr_cur < MAP_LIMIT);

  assign b_take    = b_valid && (!rsp_valid || rsp.ready);
  assign issue     = (state == ST_WALK) && (!b_valid || b_take);
  assign walk_last = ((pos + 5'd1) == total);

  assign row_step   = addr_row - ADDR_W'(grid_width);
  assign plane_step = addr_plane - ADDR_W'(plane);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      step    <= SU_ZH;
      clr_idx <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == CLR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          // a query with an empty kernel yields no items and stays here
          if (req_take && req.operation == OP_QUERY && tot_cap != 5'd0) begin
            state <= ST_SETUP;
            step  <= SU_ZH;
          end
        end
        ST_SETUP: begin
          case (step)
            SU_ZH:   step <= SU_YW;
            SU_YW:   step <= SU_BS;
            SU_BS:   step <= SU_HW;
            SU_HW:   step <= SU_DONE;
            SU_DONE: begin
              step  <= SU_ZH;
              state <= ST_WALK;
            end
            default: step <= SU_ZH;
          endcase
        end
        ST_WALK: begin
          if (issue && walk_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Query datapath: context latch, setup arithmetic, cursor stepping
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_take) begin
      q_batch <= req.batch_index;
      total   <= tot_cap;
      cur_z   <= 12'(req.coord_z) + 12'(kernel_depth >> 1);
      cur_y   <= 12'(req.coord_y) + 12'(kernel_height >> 1);
      cur_x   <= 12'(req.coord_x) + 12'(kernel_width >> 1);
      org_y   <= 12'(req.coord_y) + 12'(kernel_height >> 1);
      org_x   <= 12'(req.coord_x) + 12'(kernel_width >> 1);
      kx      <= '0;
      ky      <= '0;
      pos     <= '0;
    end

    if (state == ST_SETUP) begin
      prod <= mul_a * mul_b;
      case (step)
        SU_BS: acc <= ADDR_W'(prod) + ADDR_W'(org_x[10:0]);
        SU_HW: acc <= acc + ADDR_W'(prod);
        SU_DONE: begin
          plane      <= prod[21:0];
          addr_cur   <= acc;
          addr_row   <= acc;
          addr_plane <= acc;
        end
        default: ;
      endcase
    end

    if (issue) begin
      pos <= pos + 5'd1;
      if ((kx + 2'd1) == kernel_width) begin
        kx    <= '0;
        cur_x <= org_x;
        if ((ky + 2'd1) == kernel_height) begin
          // advance to the next kernel plane
          ky         <= '0;
          cur_y      <= org_y;
          cur_z      <= cur_z - 12'sd1;
          addr_plane <= plane_step;
          addr_row   <= plane_step;
          addr_cur   <= plane_step;
        end else begin
          ky       <= ky + 2'd1;
          cur_y    <= cur_y - 12'sd1;
          addr_row <= row_step;
          addr_cur <= row_step;
        end
      end else begin
        kx       <= kx + 2'd1;
        cur_x    <= cur_x - 12'sd1;
        addr_cur <= addr_cur - ADDR_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Map memory: one write port (clear pass or write item), one read port
  // ---------------------------------------------------------------------------
  assign mem_we = (state == ST_CLEAR) ||
                  (req_take && req.operation == OP_WRITE && wr_ok);
  assign mem_wa = (state == ST_CLEAR) ? clr_idx : AW'(req.map_address);
  assign mem_wd = (state == ST_CLEAR) ? ROW_EMPTY : req.map_value;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    if (issue) begin
      rd_data <= map_mem[AW'(addr_cur)];
    end
  end

  // ---------------------------------------------------------------------------
  // Read stage: hold the position tag next to the read data
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (issue) begin
      b_valid <= 1'b1;
    end else if (b_take) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_pos  <= pos;
      b_ok   <= z_in && y_in && x_in && in_map;
      b_addr <= row_t'(addr_cur[16:0]);
      b_last <= walk_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  assign hit = b_ok && (rd_data != ROW_EMPTY);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (b_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_take) begin
      rsp_pos   <= b_pos;
      rsp_found <= hit;
      rsp_addr  <= hit ? b_addr : ROW_EMPTY;
      rsp_row   <= hit ? rd_data : ROW_EMPTY;
      rsp_last  <= b_last;
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.kernel_position  = rsp_pos;
  assign rsp.found            = rsp_found;
  assign rsp.neighbor_address = rsp_addr;
  assign rsp.neighbor_row     = rsp_row;
  assign rsp.last             = rsp_last;

endmodule

### verif/snr_rulebook_checker.sv
// ----------------------------------------------------------------------------
// snr_rulebook_checker: result checker for the neighbor rulebook block
// Watches the request, result and configuration channels, keeps a shadow of
// the voxel map and geometry, predicts the neighbor list of every query and
// compares each result item in order.
// ----------------------------------------------------------------------------
module snr_rulebook_checker
  import snr_pkg::*;
#(
  parameter int MAP_DEPTH = MAP_DEPTH_DEF,
  parameter int KERNEL_POSITIONS = KERNEL_POS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  snr_req_if          req,
  snr_rsp_if          rsp,
  snr_cfg_if          cfg,
  output int unsigned mismatches,
  output int          pending
);

  typedef struct packed {
    logic [4:0] kernel_position;
    logic       found;
    row_t       neighbor_address;
    row_t       neighbor_row;
    logic       last;
  } neighbor_t;

  row_t        row_map [MAP_DEPTH];
  neighbor_t   neighbor_q [$];
  logic [10:0] grid_z, grid_y, grid_x;
  logic [16:0] stride_b;
  logic [1:0]  ker_z, ker_y, ker_x;

  // Queue one result per kernel position, mirrored neighbor first to last.
  function automatic void predict_neighbors(logic [3:0] batch, logic [9:0] cz,
                                            logic [9:0] cy, logic [9:0] cx);
    int        total, kd, kh, kw, kz, ky, kx, nz, ny, nx;
    longint    addr;
    neighbor_t n;
    kd = int'(ker_z);
    kh = int'(ker_y);
    kw = int'(ker_x);
    total = kd * kh * kw;
    if (total > KERNEL_POSITIONS) total = KERNEL_POSITIONS;
    for (int p = 0; p < total; p++) begin
      kx = p % kw;
      ky = (p / kw) % kh;
      kz = p / (kw * kh);
      nz = int'(cz) - kz + kd / 2;
      ny = int'(cy) - ky + kh / 2;
      nx = int'(cx) - kx + kw / 2;
      n.kernel_position = 5'(p);
      n.found = 1'b0;
      n.neighbor_address = ROW_EMPTY;
      n.neighbor_row = ROW_EMPTY;
      n.last = (p == total - 1);
      if (nz >= 0 && nz < int'(grid_z) && ny >= 0 && ny < int'(grid_y) &&
          nx >= 0 && nx < int'(grid_x)) begin
        addr = (longint'(nz) * longint'(grid_y) + ny) * longint'(grid_x) + nx
             + longint'(batch) * longint'(stride_b);
        if (addr < MAP_DEPTH) begin
          if (row_map[addr] != ROW_EMPTY) begin
            n.found = 1'b1;
            n.neighbor_address = row_t'(addr[16:0]);
            n.neighbor_row = row_map[addr];
          end
        end
      end
      neighbor_q.push_back(n);
    end
  endfunction

  function automatic void flag_error(string what, neighbor_t want, neighbor_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t rulebook %s: expected pos %0d found %0b addr %0d row %0d last %0b",
               $time, what, want.kernel_position, want.found, want.neighbor_address,
               want.neighbor_row, want.last);
    if (mismatches <= 10)
      $display("    got pos %0d found %0b addr %0d row %0d last %0b",
               got.kernel_position, got.found, got.neighbor_address,
               got.neighbor_row, got.last);
  endfunction

  always @(posedge clk) begin
    neighbor_t got, want;
    if (rst) begin
      foreach (row_map[i]) row_map[i] = ROW_EMPTY;
      neighbor_q.delete();
      grid_z = 11'd16;
      grid_y = 11'd16;
      grid_x = 11'd16;
      stride_b = 17'd4096;
      ker_z = 2'd3;
      ker_y = 2'd3;
      ker_x = 2'd3;
      mismatches = 0;
    end else begin
      // Compare before absorbing new items: nothing accepted now can answer now.
      if (rsp.valid && rsp.ready) begin
        got.kernel_position = rsp.kernel_position;
        got.found = rsp.found;
        got.neighbor_address = rsp.neighbor_address;
        got.neighbor_row = rsp.neighbor_row;
        got.last = rsp.last;
        if (neighbor_q.size() == 0) begin
          flag_error("unexpected item", '0, got);
        end else begin
          want = neighbor_q.pop_front();
          if (got !== want) flag_error("mismatch", want, got);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_GRID_DEPTH:    grid_z = cfg.data[10:0];
          CFG_GRID_HEIGHT:   grid_y = cfg.data[10:0];
          CFG_GRID_WIDTH:    grid_x = cfg.data[10:0];
          CFG_BATCH_STRIDE:  stride_b = cfg.data;
          CFG_KERNEL_DEPTH:  ker_z = cfg.data[1:0];
          CFG_KERNEL_HEIGHT: ker_y = cfg.data[1:0];
          CFG_KERNEL_WIDTH:  ker_x = cfg.data[1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.operation == OP_WRITE) begin
          if (int'(req.map_address) < MAP_DEPTH) row_map[req.map_address] = req.map_value;
        end else begin
          predict_neighbors(req.batch_index, req.coord_z, req.coord_y, req.coord_x);
        end
      end
    end
    pending = neighbor_q.size();
  end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the neighbor rulebook block
// Fills the voxel map and queries voxels over several grid and kernel
// geometries, with random stalls on both channels; a checker beside the
// block predicts every result item and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
  import snr_pkg::*;

  // Safety net only; a correct run with the map clear pass needs far less.
  localparam int LIMIT_CYCLES = 1_000_000;
  // Quiet time before a register write, covers a write item still in flight.
  localparam int SETTLE_CYCLES = 64;
  // Long receiver hold-off used once to back the block up into its input.
  localparam int HOLD_CYCLES = 300;
  // Register index past the end of the list; the block must ignore it.
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned mismatches;
  int          pending;
  int          cycle_count = 0;
  int          items_sent = 0;
  bit          tx_idle, rx_idle, hold_req, hold_taken;
  // Geometry as last written, used to aim writes at a query's neighbors.
  int          cur_gz, cur_gy, cur_gx, cur_stride;

  snr_req_if req_ch ();
  snr_rsp_if rsp_ch ();
  snr_cfg_if cfg_ch ();

  submanifold_neighbor_rulebook_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  snr_rulebook_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Result side: ready in random runs, stalls in random bursts while rx_idle
  // is set, and one long hold-off on request. Every step starts at a falling
  // edge, so ready gets a single assignment per edge.
  initial begin : result_sink
    rsp_ch.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (rx_idle && $urandom_range(0, 2) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  // Mostly ordinary rows, now and then empty or any 17 bit pattern
  // (negative rows other than empty must still count as found).
  function automatic row_t random_row();
    case ($urandom_range(0, 7))
      0: return ROW_EMPTY;
      1: return row_t'($urandom_range(0, 131071));
      default: return row_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int coord_span(int extent, int cap);
    int lim;
    lim = (extent < cap) ? extent : cap;
    return (lim < 1) ? 1 : lim;
  endfunction

  // Offer one item at a falling edge and hold it until taken. Leave valid
  // high afterwards; the next item or a settle drops or replaces it.
  task automatic push_item(op_t op, logic [15:0] addr, row_t value, logic [3:0] batch,
                           logic [9:0] z, logic [9:0] y, logic [9:0] x);
    if (tx_idle && $urandom_range(0, 2) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.operation   <= op;
    req_ch.map_address <= addr;
    req_ch.map_value   <= value;
    req_ch.batch_index <= batch;
    req_ch.coord_z     <= z;
    req_ch.coord_y     <= y;
    req_ch.coord_x     <= x;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Fields a write ignores get random junk, and the other way round.
  task automatic write_entry(logic [15:0] addr, row_t value);
    push_item(OP_WRITE, addr, value, 4'($urandom_range(0, 15)),
              10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
              10'($urandom_range(0, 1023)));
  endtask

  task automatic query_voxel(logic [3:0] batch, logic [9:0] z, logic [9:0] y,
                             logic [9:0] x);
    push_item(OP_QUERY, 16'($urandom_range(0, 65535)), random_row(), batch, z, y, x);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [16:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Write all seven registers and mirror the masked values for aiming.
  task automatic set_geometry(logic [16:0] gz, logic [16:0] gy, logic [16:0] gx,
                              logic [16:0] stride, logic [16:0] kz, logic [16:0] ky,
                              logic [16:0] kx);
    cfg_write(CFG_GRID_DEPTH, gz);
    cfg_write(CFG_GRID_HEIGHT, gy);
    cfg_write(CFG_GRID_WIDTH, gx);
    cfg_write(CFG_BATCH_STRIDE, stride);
    cfg_write(CFG_KERNEL_DEPTH, kz);
    cfg_write(CFG_KERNEL_HEIGHT, ky);
    cfg_write(CFG_KERNEL_WIDTH, kx);
    cfg_ch.valid <= 1'b0;
    cur_gz = int'(gz[10:0]);
    cur_gy = int'(gy[10:0]);
    cur_gx = int'(gx[10:0]);
    cur_stride = int'(stride);
  endtask

  // Drop valid and wait until every predicted result has been taken; with
  // tail set, also let a trailing write item drain before a register write.
  task automatic settle(bit tail);
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    if (tail) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Well-formed burst: populate a few neighbors of a voxel, then query it.
  // Half the centers hug the origin so that large grids still hit the map.
  task automatic voxel_burst();
    int         cap, cz, cy, cx, z, y, x;
    logic [3:0] batch;
    longint     addr;
    cap = ($urandom_range(0, 1) == 0) ? 4 : 1024;
    cz = $urandom_range(0, coord_span(cur_gz, cap) - 1);
    cy = $urandom_range(0, coord_span(cur_gy, cap) - 1);
    cx = $urandom_range(0, coord_span(cur_gx, cap) - 1);
    batch = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                        : 4'($urandom_range(0, 1));
    repeat ($urandom_range(0, 6)) begin
      z = cz + int'($urandom_range(0, 2)) - 1;
      y = cy + int'($urandom_range(0, 2)) - 1;
      x = cx + int'($urandom_range(0, 2)) - 1;
      if (z >= 0 && z < cur_gz && y >= 0 && y < cur_gy && x >= 0 && x < cur_gx)
        addr = (longint'(z) * cur_gy + y) * cur_gx + x + longint'(batch) * cur_stride;
      else
        addr = $urandom_range(0, 65535);
      // Neighbor past the map: scatter the write instead.
      if (addr >= MAP_DEPTH_DEF) addr = $urandom_range(0, 65535);
      write_entry(addr[15:0], random_row());
    end
    query_voxel(batch, cz[9:0], cy[9:0], cx[9:0]);
  endtask

  // Random traffic: mostly bursts, a quarter noise over the full field
  // ranges. Idling flips on and off so that quiet stretches appear too.
  task automatic random_phase(int n, bit idle_ok);
    int stop;
    stop = items_sent + n;
    tx_idle = idle_ok ? 1'($urandom_range(0, 1)) : 1'b0;
    rx_idle = idle_ok ? 1'($urandom_range(0, 1)) : 1'b0;
    while (items_sent < stop) begin
      if (idle_ok && $urandom_range(0, 7) == 0) begin
        tx_idle = 1'($urandom_range(0, 1));
        rx_idle = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 3) != 0)
        voxel_burst();
      else if ($urandom_range(0, 1) == 0)
        write_entry(16'($urandom_range(0, 65535)), random_row());
      else
        query_voxel(4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)),
                    10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    end
  endtask

  initial begin : stimulus
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_WRITE;
    req_ch.map_address = '0;
    req_ch.map_value = '0;
    req_ch.batch_index = '0;
    req_ch.coord_z = '0;
    req_ch.coord_y = '0;
    req_ch.coord_x = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Register writes go in while the map clear pass still runs.
    cfg_write(CFG_UNUSED, 17'h1ABCD);
    set_geometry(17'd16, 17'd16, 17'd16, 17'd4096, 17'd3, 17'd3, 17'd3);

    // Directed: 16^3 grid, voxel address is z*256 + y*16 + x per batch.
    write_entry(16'd0, row_t'(0));
    write_entry(16'd1, row_t'(65535));
    write_entry(16'd16, row_t'(-2));             // negative but not empty
    write_entry(16'd256, row_t'(17'h10000));     // most negative row
    write_entry(16'd273, row_t'(5));
    write_entry(16'd4095, row_t'(77));
    write_entry(16'd4096, row_t'(9));
    write_entry(16'd65535, row_t'(123));         // top of the map
    query_voxel(4'd0, 10'd0, 10'd0, 10'd0);      // corner, most neighbors outside
    query_voxel(4'd0, 10'd1, 10'd1, 10'd1);      // fully inside
    query_voxel(4'd0, 10'd15, 10'd15, 10'd15);   // far corner
    query_voxel(4'd15, 10'd15, 10'd15, 10'd15);  // last batch hits the top entry
    query_voxel(4'd1, 10'd0, 10'd0, 10'd0);
    query_voxel(4'd15, 10'd1023, 10'd1023, 10'd1023);
    write_entry(16'd1, ROW_EMPTY);               // clear an entry again
    query_voxel(4'd0, 10'd0, 10'd0, 10'd0);
    // Ignored fields at all ones.
    push_item(OP_WRITE, 16'd2, row_t'(17'h0FFFF), 4'hF, 10'h3FF, 10'h3FF, 10'h3FF);
    push_item(OP_QUERY, 16'hFFFF, row_t'(17'h0FFFF), 4'd0, 10'd2, 10'd2, 10'd2);

    random_phase(24, 1'b1);
    // Hold results off for a long stretch while queries keep coming, so the
    // block fills up and stalls its input.
    hold_req = 1'b1;
    repeat (6) query_voxel(4'($urandom_range(0, 1)), 10'($urandom_range(0, 15)),
                           10'($urandom_range(0, 15)), 10'($urandom_range(0, 15)));
    // Pause the sender until every result is back, then carry on.
    settle(1'b0);
    random_phase(24, 1'b1);

    // Grid of 1024 per side, stride 65536: anything past batch 0 or z 0 leaves the map.
    settle(1'b1);
    set_geometry(17'd1024, 17'd1024, 17'd1024, 17'd65536, 17'd3, 17'd3, 17'd3);
    query_voxel(4'd0, 10'd0, 10'd0, 10'd0);
    query_voxel(4'd1, 10'd0, 10'd0, 10'd0);
    query_voxel(4'd0, 10'd1023, 10'd1023, 10'd1023);
    random_phase(24, 1'b1);

    // Small grid with a non-cubic kernel.
    settle(1'b1);
    set_geometry(17'd4, 17'd4, 17'd4, 17'd64, 17'd3, 17'd2, 17'd1);
    random_phase(32, 1'b1);

    // Uneven grid; upper data bits must be masked off (grid height 3, kernel width 2).
    settle(1'b1);
    set_geometry(17'd8, 17'h1F803, 17'd5, 17'd120, 17'd2, 17'd1, 17'h1FFFE);
    random_phase(24, 1'b1);

    // Zero grid height with the widest fields: nothing is ever found.
    settle(1'b1);
    set_geometry(17'd2047, 17'd0, 17'd1, 17'd131071, 17'd1, 17'd3, 17'd3);
    query_voxel(4'd0, 10'd5, 10'd0, 10'd0);
    random_phase(8, 1'b1);

    // Zero kernel depth: queries produce no results at all.
    settle(1'b1);
    set_geometry(17'd16, 17'd16, 17'd16, 17'd1, 17'd0, 17'd2, 17'd3);
    query_voxel(4'd0, 10'd1, 10'd1, 10'd1);
    random_phase(8, 1'b1);

    // Single voxel grid, single position kernel.
    settle(1'b1);
    set_geometry(17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1);
    random_phase(16, 1'b1);

    // Back to the reset geometry, no idling on either side to the end.
    settle(1'b1);
    set_geometry(17'd16, 17'd16, 17'd16, 17'd4096, 17'd3, 17'd3, 17'd3);
    random_phase(24, 1'b0);

    settle(1'b1);
    if (mismatches == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
